FILE: sv/cigar_alignment_walker_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the CIGAR alignment walker
// Concurrent checks clocked on the rising edge, held off during reset.
// ----------------------------------------------------------------------------
`ifndef CIGAR_ALIGNMENT_WALKER_ASSERT_SVH
`define CIGAR_ALIGNMENT_WALKER_ASSERT_SVH

// Same-cycle implication.
`define CAW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("caw check failed");

// Next-cycle implication.
`define CAW_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("caw check failed");

`endif

FILE: sv/caw_pkg.sv
// ----------------------------------------------------------------------------
// caw_pkg
// Types and constants shared by the CIGAR alignment walker modules.
// ----------------------------------------------------------------------------
`default_nettype none

package caw_pkg;

    // Event kinds on the result channel.
    typedef enum logic [2:0] {
        KIND_MATCH    = 3'd0,
        KIND_MISMATCH = 3'd1,
        KIND_INS      = 3'd2,
        KIND_DEL      = 3'd3,
        KIND_SKIP     = 3'd4,
        KIND_SOFT     = 3'd5,
        KIND_HARD     = 3'd6,
        KIND_BAD      = 3'd7
    } t_kind;

    // CIGAR operation codes.
    localparam logic [3:0] OP_M = 4'd0;
    localparam logic [3:0] OP_I = 4'd1;
    localparam logic [3:0] OP_D = 4'd2;
    localparam logic [3:0] OP_N = 4'd3;
    localparam logic [3:0] OP_S = 4'd4;
    localparam logic [3:0] OP_H = 4'd5;

    // Command codes.
    localparam logic CMD_START = 1'b0;

    localparam logic [7:0] BASE_N = 8'h4E;

    // How a cursor moves for one step.
    typedef enum logic [1:0] {
        ADV_NONE = 2'd0,
        ADV_ONE  = 2'd1,
        ADV_LEN  = 2'd2
    } t_adv;

    // One classified step, passed from the front to the back.
    typedef struct packed {
        logic        is_start;
        logic        emit;
        t_kind       kind;
        t_adv        q_adv;
        t_adv        r_adv;
        logic [31:0] value;     // start minus one on start, op length on I, D, N, S, H, else zero
        logic [7:0]  ref_up;
        logic [7:0]  qry_up;
    } t_step;

    // Queue status toward the front and the back.
    typedef struct packed {
        logic       empty;
        logic       full;
        logic [1:0] count;
    } t_q_status;

    function automatic logic [7:0] upcase(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= 8'h61 && b <= 8'h7A) begin
            r = b - 8'h20;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: sv/caw_front.sv
// ----------------------------------------------------------------------------
// caw_front
// Decodes one input item into a step: event kind, bases, cursor moves.
// ----------------------------------------------------------------------------
`default_nettype none

module caw_front
    import caw_pkg::*;
(
    input  wire logic        i_cmd,
    input  wire logic [31:0] i_start_position,
    input  wire logic [3:0]  i_op_code,
    input  wire logic [27:0] i_op_length,
    input  wire logic [7:0]  i_ref_base,
    input  wire logic [7:0]  i_query_base,
    output t_step            o_step
);

    logic [7:0] w_ref_up;
    logic [7:0] w_qry_up;

    assign w_ref_up = upcase(i_ref_base);
    assign w_qry_up = upcase(i_query_base);

    always_comb begin
        o_step          = '0;
        o_step.kind     = KIND_BAD;
        o_step.q_adv    = ADV_NONE;
        o_step.r_adv    = ADV_NONE;
        o_step.is_start = 1'b0;
        o_step.emit     = 1'b1;
        if (i_cmd == CMD_START) begin
            o_step.is_start = 1'b1;
            o_step.emit     = 1'b0;
            o_step.value    = i_start_position - 32'd1;
        end else begin
            case (i_op_code)
                OP_M: begin
                    o_step.ref_up = w_ref_up;
                    o_step.qry_up = w_qry_up;
                    o_step.q_adv  = ADV_ONE;
                    o_step.r_adv  = ADV_ONE;
                    if (i_ref_base == i_query_base) begin
                        o_step.kind = KIND_MATCH;
                    end else begin
                        o_step.kind = KIND_MISMATCH;
                        // drop pairs where either base is unknown
                        o_step.emit = (w_ref_up != BASE_N) && (w_qry_up != BASE_N);
                    end
                end
                OP_I: begin
                    o_step.kind  = KIND_INS;
                    o_step.value = {4'b0, i_op_length};
                    o_step.q_adv = ADV_LEN;
                end
                OP_D: begin
                    o_step.kind  = KIND_DEL;
                    o_step.value = {4'b0, i_op_length};
                    o_step.r_adv = ADV_LEN;
                end
                OP_N: begin
                    o_step.kind  = KIND_SKIP;
                    o_step.value = {4'b0, i_op_length};
                    o_step.r_adv = ADV_LEN;
                end
                OP_S: begin
                    o_step.kind  = KIND_SOFT;
                    o_step.value = {4'b0, i_op_length};
                    o_step.q_adv = ADV_LEN;
                end
                OP_H: begin
                    o_step.kind  = KIND_HARD;
                    o_step.value = {4'b0, i_op_length};
                end
                default: begin
                    o_step.kind = KIND_BAD;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: sv/caw_queue.sv
// ----------------------------------------------------------------------------
// caw_queue
// Two-entry queue of classified steps between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module caw_queue
    import caw_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_step i_step,
    input  wire logic  i_pop,
    output t_step      o_step,
    output t_q_status  o_status
);

    t_step      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_step;
        end
    end

    assign o_step         = r_mem[r_rd_ptr];
    assign o_status.empty = (r_count == 2'd0);
    assign o_status.full  = (r_count == 2'd2);
    assign o_status.count = r_count;

endmodule

`default_nettype wire

FILE: sv/caw_back.sv
// ----------------------------------------------------------------------------
// caw_back
// Applies queued steps to the cursors and registers the result events.
// ----------------------------------------------------------------------------
`default_nettype none

module caw_back
    import caw_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_step         i_step,
    input  wire t_q_status     i_q_status,
    output logic               o_pop,
    output logic               o_m_tvalid,
    input  wire logic          i_m_tready,
    output logic [2:0]         o_m_kind,
    output logic [31:0]        o_m_qpos,
    output logic [31:0]        o_m_rpos,
    output logic [7:0]         o_m_rbu,
    output logic [7:0]         o_m_qbu,
    output logic [27:0]        o_m_len
);

    logic [31:0] r_qry;
    logic [31:0] r_ref;
    logic [31:0] n_qry;
    logic [31:0] n_ref;
    logic        r_out_valid;
    t_kind       r_kind;
    logic [31:0] r_qpos;
    logic [31:0] r_rpos;
    logic [7:0]  r_rbu;
    logic [7:0]  r_qbu;
    logic [27:0] r_len;

    // Take the next step whenever the result register is free or draining.
    assign o_pop = !i_q_status.empty && (!r_out_valid || i_m_tready);

    always_comb begin
        n_qry = r_qry;
        n_ref = r_ref;
        if (i_step.is_start) begin
            n_qry = 32'd0;
            n_ref = i_step.value;
        end else begin
            case (i_step.q_adv)
                ADV_ONE: n_qry = r_qry + 32'd1;
                ADV_LEN: n_qry = r_qry + i_step.value;
                default: n_qry = r_qry;
            endcase
            case (i_step.r_adv)
                ADV_ONE: n_ref = r_ref + 32'd1;
                ADV_LEN: n_ref = r_ref + i_step.value;
                default: n_ref = r_ref;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qry       <= 32'd0;
            r_ref       <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_qry       <= n_qry;
                r_ref       <= n_ref;
                r_out_valid <= i_step.emit;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_step.emit) begin
            r_kind <= i_step.kind;
            r_qpos <= r_qry;
            r_rpos <= r_ref;
            r_rbu  <= i_step.ref_up;
            r_qbu  <= i_step.qry_up;
            r_len  <= i_step.value[27:0];
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_kind   = r_kind;
    assign o_m_qpos   = r_qpos;
    assign o_m_rpos   = r_rpos;
    assign o_m_rbu    = r_rbu;
    assign o_m_qbu    = r_qbu;
    assign o_m_len    = r_len;

endmodule

`default_nettype wire

FILE: sv/cigar_alignment_walker.sv
// ----------------------------------------------------------------------------
// cigar_alignment_walker
// Walks CIGAR steps of one read with query and reference cursors and
// emits match, mismatch, indel, skip, clip and bad-op events.
// ----------------------------------------------------------------------------
//  channel  dir  tdata (low bit up)                               tuser
//  s_axis   in   start_position 32, op_code 4, op_length 28,       cmd
//                ref_base 8, query_base 8
//  m_axis   out  query_position 32, ref_position 32,               event_kind
//                ref_base_upper 8, query_base_upper 8,
//                event_length 28, 4 zero bits
//
// One item per cycle sustained while the result channel takes events; an
// event passes through the queue slot and then the result register after
// its item is taken.
// Reset clears both cursors, the two-entry step queue and the result valid.
// A stalled result only blocks the back; the front keeps taking items until
// the queue holds two steps.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cigar_alignment_walker_assert.svh"

module cigar_alignment_walker
    import caw_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [79:0]  s_axis_tdata,   // start_position, op_code, op_length,
                                              // ref_base, query_base
    input  wire logic         s_axis_tuser,   // cmd
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [111:0]      m_axis_tdata,   // query_position, ref_position,
                                              // ref_base_upper, query_base_upper,
                                              // event_length
    output logic [2:0]        m_axis_tuser    // event_kind
);

    t_step      w_front_step;
    t_step      w_q_step;
    t_q_status  w_q_status;
    logic       w_push;
    logic       w_pop;
    logic [31:0] w_qpos;
    logic [31:0] w_rpos;
    logic [7:0]  w_rbu;
    logic [7:0]  w_qbu;
    logic [27:0] w_len;
    logic        w_base_event;
    logic        w_no_len;
    logic        w_start_idle;

    assign s_axis_tready = !w_q_status.full;
    assign w_push        = s_axis_tvalid && s_axis_tready;

    caw_front u_front (
        .i_cmd            (s_axis_tuser),
        .i_start_position (s_axis_tdata[31:0]),
        .i_op_code        (s_axis_tdata[35:32]),
        .i_op_length      (s_axis_tdata[63:36]),
        .i_ref_base       (s_axis_tdata[71:64]),
        .i_query_base     (s_axis_tdata[79:72]),
        .o_step           (w_front_step)
    );

    caw_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_step   (w_front_step),
        .i_pop    (w_pop),
        .o_step   (w_q_step),
        .o_status (w_q_status)
    );

    caw_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_q_step),
        .i_q_status (w_q_status),
        .o_pop      (w_pop),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_kind   (m_axis_tuser),
        .o_m_qpos   (w_qpos),
        .o_m_rpos   (w_rpos),
        .o_m_rbu    (w_rbu),
        .o_m_qbu    (w_qbu),
        .o_m_len    (w_len)
    );

    assign m_axis_tdata = {4'b0, w_len, w_qbu, w_rbu, w_rpos, w_qpos};

    assign w_base_event = (m_axis_tuser == KIND_MATCH) || (m_axis_tuser == KIND_MISMATCH);
    assign w_no_len     = w_base_event || (m_axis_tuser == KIND_BAD);
    assign w_start_idle = w_push && (s_axis_tuser == CMD_START) && w_q_status.empty
                          && !m_axis_tvalid;

    `CAW_ASSERT_IMP(a_match_no_len, i_clk, i_rst_n, m_axis_tvalid && w_no_len, w_len == 28'd0)
    `CAW_ASSERT_IMP(a_nonbase_zero, i_clk, i_rst_n, m_axis_tvalid && !w_base_event, {w_qbu, w_rbu} == 16'd0)
    `CAW_ASSERT_IMP(a_pop_nonempty, i_clk, i_rst_n, w_pop, w_q_status.count != 2'd0)
    `CAW_ASSERT_NXT(a_start_silent, i_clk, i_rst_n, w_start_idle, !m_axis_tvalid)

endmodule

`default_nettype wire

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb: CIGAR alignment walker testbench
// Drives read starts, aligned base pairs and CIGAR steps into the walker,
// predicts each event from a cursor model kept here, and checks every event
// field against the oldest prediction under random source gaps and sink
// stalls.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import caw_pkg::*;

    // Codes not named by the package.
    localparam logic       CMD_STEP = 1'b1;
    localparam logic [3:0] OP_P     = 4'd6;
    localparam logic [3:0] OP_EQ    = 4'd7;
    localparam logic [3:0] OP_X     = 4'd8;
    localparam logic [3:0] OP_B     = 4'd9;
    localparam logic [3:0] OP_LAST  = 4'd15;

    localparam logic [27:0] LEN_MAX        = 28'hFFFFFFF;
    localparam logic [79:0] BASE_SET       = "ACGTNacgtn";
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          DRAIN_CYCLES   = 8;
    localparam int          RANDOM_ITEMS   = 1300;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] qpos;
        logic [31:0] rpos;
        logic [7:0]  rbu;
        logic [7:0]  qbu;
        logic [27:0] len;
    } t_walk_event;

    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [79:0]  s_axis_tdata  = '0;  // start_position, op_code, op_length,
                                       // ref_base, query_base
    logic         s_axis_tuser  = 1'b0; // cmd
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [111:0] m_axis_tdata;        // query_position, ref_position,
                                       // ref_base_upper, query_base_upper,
                                       // event_length
    logic [2:0]   m_axis_tuser;        // event_kind

    // Cursor model and predicted events.
    logic [31:0]   qry_cursor = '0;
    logic [31:0]   ref_cursor = '0;
    t_walk_event   pending_events[$];
    int unsigned   fail_count = 0;

    // Source burst shaping.
    int unsigned   burst_left  = 0;
    int unsigned   idle_cycles = 0;

    // Sink stall pattern.
    int unsigned   rx_mode  = 0;
    int unsigned   rx_hold  = 0;
    int unsigned   rx_tick  = 0;
    int unsigned   stall_cycles = 0;

    cigar_alignment_walker u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [7:0] to_upper(input logic [7:0] b);
        if (b >= "a" && b <= "z") begin
            return b - 8'h20;
        end
        return b;
    endfunction

    // Advance the cursors for one accepted request and queue its event.
    function automatic void walk_cigar_step(input logic cmd, input logic [31:0] start,
                                            input logic [3:0] op, input logic [27:0] len,
                                            input logic [7:0] rb, input logic [7:0] qb);
        t_walk_event ev;
        logic        produces;
        if (cmd == CMD_START) begin
            ref_cursor = start - 32'd1;
            qry_cursor = '0;
            return;
        end
        ev       = '0;
        ev.qpos  = qry_cursor;
        ev.rpos  = ref_cursor;
        produces = 1'b1;
        case (op)
            OP_M: begin
                ev.rbu = to_upper(rb);
                ev.qbu = to_upper(qb);
                if (rb == qb) begin
                    ev.kind = KIND_MATCH;
                end else if (ev.rbu != BASE_N && ev.qbu != BASE_N) begin
                    ev.kind = KIND_MISMATCH;
                end else begin
                    produces = 1'b0;
                end
                qry_cursor = qry_cursor + 32'd1;
                ref_cursor = ref_cursor + 32'd1;
            end
            OP_I: begin
                ev.kind    = KIND_INS;
                ev.len     = len;
                qry_cursor = qry_cursor + {4'd0, len};
            end
            OP_D: begin
                ev.kind    = KIND_DEL;
                ev.len     = len;
                ref_cursor = ref_cursor + {4'd0, len};
            end
            OP_N: begin
                ev.kind    = KIND_SKIP;
                ev.len     = len;
                ref_cursor = ref_cursor + {4'd0, len};
            end
            OP_S: begin
                ev.kind    = KIND_SOFT;
                ev.len     = len;
                qry_cursor = qry_cursor + {4'd0, len};
            end
            OP_H: begin
                ev.kind = KIND_HARD;
                ev.len  = len;
            end
            default: begin
                ev.kind = KIND_BAD;
            end
        endcase
        if (produces) begin
            pending_events = {pending_events, ev};
        end
    endfunction

    // Send one request; return at the edge that accepts it.
    task automatic send_item(input logic cmd, input logic [31:0] start,
                             input logic [3:0] op, input logic [27:0] len,
                             input logic [7:0] rb, input logic [7:0] qb);
        if (idle_cycles > 0) begin
            repeat (idle_cycles) @(posedge i_clk);
            idle_cycles = 0;
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {qb, rb, len, op, start};
        do @(posedge i_clk); while (!s_axis_tready);
        walk_cigar_step(cmd, start, op, len, rb, qb);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 40);
            if ($urandom_range(0, 3) != 0) begin
                idle_cycles = $urandom_range(1, 12);
                s_axis_tvalid <= 1'b0;
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    function automatic logic [7:0] pick_base();
        if ($urandom_range(0, 3) == 0) begin
            return 8'($urandom);
        end
        return BASE_SET[8 * $urandom_range(0, 9) +: 8];
    endfunction

    function automatic logic [27:0] rand_length();
        case ($urandom_range(0, 9))
            0, 1:    return 28'($urandom);
            2:       return ($urandom_range(0, 1) != 0) ? LEN_MAX : 28'd0;
            default: return 28'($urandom_range(0, 50));
        endcase
    endfunction

    // Check events and shape the sink stalls.
    always @(posedge i_clk) begin
        t_walk_event want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_events.size() == 0) begin
                $display("%0t: event with none expected: expected none, actual kind %0d data %h",
                         $time, m_axis_tuser, m_axis_tdata);
                fail_count++;
            end else begin
                want = pending_events.pop_front();
                check_field("event_kind", 32'(want.kind), 32'(m_axis_tuser));
                check_field("query_position", want.qpos, m_axis_tdata[31:0]);
                check_field("ref_position", want.rpos, m_axis_tdata[63:32]);
                check_field("ref_base_upper", 32'(want.rbu), 32'(m_axis_tdata[71:64]));
                check_field("query_base_upper", 32'(want.qbu), 32'(m_axis_tdata[79:72]));
                check_field("event_length", 32'(want.len), 32'(m_axis_tdata[107:80]));
            end
        end
        if (rx_hold == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_hold = $urandom_range(16, 200);
        end else begin
            rx_hold--;
        end
        rx_tick++;
        case (rx_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= ((rx_tick % 16) < 8);
        endcase
    end

    // End the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Raw compare, case folding and the N rule on match steps.
    task automatic test_base_compare();
        send_item(CMD_START, 32'd1, OP_LAST, LEN_MAX, 8'hFF, 8'hFF);
        send_item(CMD_STEP, 32'hFFFFFFFF, OP_M, 28'd0, "A", "A");
        send_item(CMD_STEP, 32'd0, OP_M, 28'd0, "a", "a");
        send_item(CMD_STEP, 32'd0, OP_M, 28'd0, "a", "A");
        send_item(CMD_STEP, 32'd0, OP_M, 28'd0, "g", "c");
        send_item(CMD_STEP, 32'd0, OP_M, 28'd0, "N", "A");
        send_item(CMD_STEP, 32'd0, OP_M, 28'd0, "T", "n");
        send_item(CMD_STEP, 32'd0, OP_M, 28'd0, "N", "N");
        send_item(CMD_STEP, 32'd0, OP_M, 28'd0, "n", "N");
        send_item(CMD_STEP, 32'd0, OP_M, 28'd0, 8'h60, 8'h7B);
        send_item(CMD_STEP, 32'd0, OP_M, 28'd0, 8'hFF, 8'h00);
        send_item(CMD_STEP, 32'd0, OP_M, LEN_MAX, "z", "Z");
    endtask

    // Operation codes 0 to 9 and 15, zero and full lengths, start position wrap.
    task automatic test_operations();
        send_item(CMD_START, 32'd0, OP_M, 28'd0, 8'h00, 8'h00);
        send_item(CMD_STEP, 32'd0, OP_M, 28'd0, "C", "C");
        send_item(CMD_STEP, 32'd0, OP_I, 28'd5, 8'h00, 8'h00);
        send_item(CMD_STEP, 32'd0, OP_D, 28'd3, 8'h00, 8'h00);
        send_item(CMD_STEP, 32'd0, OP_N, LEN_MAX, 8'h00, 8'h00);
        send_item(CMD_STEP, 32'd0, OP_S, 28'd0, 8'h00, 8'h00);
        send_item(CMD_STEP, 32'd0, OP_H, 28'd7, 8'h00, 8'h00);
        send_item(CMD_STEP, 32'd0, OP_P, 28'd9, 8'h00, 8'h00);
        send_item(CMD_STEP, 32'd0, OP_EQ, 28'd1, "A", "A");
        send_item(CMD_STEP, 32'd0, OP_X, 28'd2, "A", "C");
        send_item(CMD_STEP, 32'd0, OP_B, 28'd3, 8'h00, 8'h00);
        send_item(CMD_STEP, 32'd0, OP_LAST, LEN_MAX, 8'hFF, 8'hFF);
        send_item(CMD_START, 32'hFFFFFFFF, OP_M, 28'd0, 8'h00, 8'h00);
        send_item(CMD_STEP, 32'd0, OP_D, LEN_MAX, 8'h00, 8'h00);
    endtask

    // Mostly well-formed reads with random content, some noise in between.
    task automatic test_random_reads(input int unsigned item_goal);
        int unsigned sent;
        int unsigned n_ops;
        int unsigned run;
        int unsigned sel;
        bit          long_haul;
        logic [3:0]  op;
        logic [7:0]  rb;
        logic [7:0]  qb;
        logic [31:0] start;
        sent = 0;
        while (sent < item_goal) begin
            if ($urandom_range(0, 9) == 0) begin
                send_item(1'($urandom_range(0, 1)), $urandom, 4'($urandom_range(0, 15)),
                          rand_length(), 8'($urandom), 8'($urandom));
                sent++;
            end else begin
                case ($urandom_range(0, 9))
                    0:       start = $urandom;
                    1:       start = ($urandom_range(0, 1) != 0) ? 32'hFFFFFFFF : 32'd0;
                    2:       start = 32'd1;
                    default: start = $urandom_range(1, 1000000);
                endcase
                send_item(CMD_START, start, 4'($urandom_range(0, 15)), 28'($urandom),
                          8'($urandom), 8'($urandom));
                sent++;
                // long clip and indel runs push the cursors through their wrap
                long_haul = ($urandom_range(0, 19) == 0);
                n_ops = long_haul ? $urandom_range(20, 30) : $urandom_range(1, 12);
                for (int k = 0; k < n_ops; k++) begin
                    sel = $urandom_range(0, 19);
                    if (long_haul) begin
                        case (sel % 4)
                            0:       op = OP_I;
                            1:       op = OP_S;
                            2:       op = OP_D;
                            default: op = OP_N;
                        endcase
                        send_item(CMD_STEP, $urandom, op,
                                  28'($urandom_range(28'h8000000, LEN_MAX)),
                                  8'($urandom), 8'($urandom));
                        sent++;
                    end else if (sel < 10) begin
                        run = $urandom_range(1, 16);
                        repeat (run) begin
                            rb = pick_base();
                            qb = ($urandom_range(0, 4) < 3) ? rb : pick_base();
                            send_item(CMD_STEP, $urandom, OP_M, 28'($urandom), rb, qb);
                            sent++;
                        end
                    end else if (sel < 18) begin
                        case (sel % 5)
                            0:       op = OP_I;
                            1:       op = OP_D;
                            2:       op = OP_N;
                            3:       op = OP_S;
                            default: op = OP_H;
                        endcase
                        send_item(CMD_STEP, $urandom, op, rand_length(),
                                  8'($urandom), 8'($urandom));
                        sent++;
                    end else begin
                        send_item(CMD_STEP, $urandom, 4'($urandom_range(OP_P, OP_LAST)),
                                  rand_length(), 8'($urandom), 8'($urandom));
                        sent++;
                    end
                end
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_base_compare();
        test_operations();
        test_random_reads(RANDOM_ITEMS);
        if (idle_cycles == 0) begin
            s_axis_tvalid <= 1'b0;
        end
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
